### sv/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 128;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned COUNT_W      = 8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
    } t_cell_op;

endpackage

### sv/mhpq_cell.sv
// One cell of the sorted key chain: holds a key and shifts with its neighbors.
module mhpq_cell (
    input  logic                             i_clk,
    input  mhpq_pkg::t_cell_op               i_op,
    input  logic                             i_occ,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_left_key,
    input  logic                             i_left_before,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_right_key,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_key,
    output logic                             o_before
);

    logic signed [mhpq_pkg::KEY_W-1:0] r_key;
    logic signed [mhpq_pkg::KEY_W-1:0] n_key;

    // new key belongs at or ahead of this slot
    assign o_before = !i_occ || (i_op.key > r_key);
    assign o_key    = r_key;

    always_comb begin
        n_key = r_key;
        if (i_op.ins) begin
            if (o_before) begin
                n_key = i_left_before ? i_left_key : i_op.key;
            end
        end else if (i_op.rem) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### sv/max_heap_priority_queue.sv
// Top level of the priority queue: request handshake, count and the cell chain.
//
// Usage: a request on the input channel (i_valid, o_stall, i_mode, i_key)
// either inserts i_key or removes the largest key held. Keys are kept in a
// chain of CAPACITY cells sorted largest first; the cells shift in
// parallel, so each request is applied to the whole chain at once.
// Each accepted request yields one result on the output channel (o_valid,
// i_stall): status, removed key, largest key left and entry count.
// Latency: the result is presented the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver does not stall, set
// by the parallel shift of the chain and the one-entry output register.
// A remove on an empty queue or an insert on a full one is flagged in the
// status and changes nothing.
// Reset clears the entry count and the output valid; cell contents need no
// clearing since only occupied cells are ever read.
// While the receiver stalls, the result holds and a new request is taken
// only if the output register is free.
module max_heap_priority_queue #(
    parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_mode,
    input  logic signed [mhpq_pkg::KEY_W-1:0]      i_key,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic        [mhpq_pkg::STATUS_W-1:0]   o_status,
    output logic signed [mhpq_pkg::KEY_W-1:0]      o_removed_key,
    output logic signed [mhpq_pkg::KEY_W-1:0]      o_top_key,
    output logic        [mhpq_pkg::COUNT_W-1:0]    o_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;

    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    mhpq_pkg::t_cell_op                cell_op;
    logic        [mhpq_pkg::STATUS_W-1:0] n_status;
    logic signed [mhpq_pkg::KEY_W-1:0] n_removed;
    logic signed [mhpq_pkg::KEY_W-1:0] n_top;

    logic signed [mhpq_pkg::KEY_W-1:0] w_key    [CAPACITY];
    logic                              w_before [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);

    assign cell_op.ins = accept && (i_mode == mhpq_pkg::MODE_INSERT) && !is_full;
    assign cell_op.rem = accept && (i_mode == mhpq_pkg::MODE_REMOVE) && !is_empty;
    assign cell_op.key = i_key;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [mhpq_pkg::KEY_W-1:0] left_key;
            logic                              left_before;
            logic signed [mhpq_pkg::KEY_W-1:0] right_key;
            if (gi == 0) begin : g_first
                assign left_key    = i_key;
                assign left_before = 1'b0;
            end else begin : g_mid
                assign left_key    = w_key[gi-1];
                assign left_before = w_before[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_key = w_key[gi];
            end else begin : g_inner
                assign right_key = w_key[gi+1];
            end
            mhpq_cell u_cell (
                .i_clk         (i_clk),
                .i_op          (cell_op),
                .i_occ         (CW'(gi) < r_count),
                .i_left_key    (left_key),
                .i_left_before (left_before),
                .i_right_key   (right_key),
                .o_key         (w_key[gi]),
                .o_before      (w_before[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_status  = mhpq_pkg::ST_OK;
        n_removed = '0;
        n_top     = is_empty ? '0 : w_key[0];
        if (i_mode == mhpq_pkg::MODE_INSERT) begin
            if (is_full) begin
                n_status = mhpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
                n_top   = w_before[0] ? i_key : w_key[0];
            end
        end else begin
            if (is_empty) begin
                n_status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_count   = r_count - CW'(1);
                n_removed = w_key[0];
                n_top     = (r_count == CW'(1)) ? '0 : w_key[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_status      <= n_status;
            o_removed_key <= n_removed;
            o_top_key     <= n_top;
            o_count       <= mhpq_pkg::COUNT_W'(n_count);
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_key[0] >= w_key[1]))
        else $error("cell chain out of order at head");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mhpq_pkg::ST_EMPTY)) |->
            (o_count == '0 && o_top_key == '0 && r_count == '0))
        else $error("empty flag with keys held");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_count == $past(r_count))
                    || (r_count == $past(r_count) + CW'(1))
                    || (r_count == $past(r_count) - CW'(1))))
        else $error("entry count moved by more than one");
`endif

endmodule

### tb/tb_max_heap_priority_queue.sv
// Testbench for max_heap_priority_queue: requests checked against a heap predictor.
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;

    localparam int unsigned CAP         = mhpq_pkg::CAPACITY_DEF;
    localparam int          MAX_REPORTS = 10;
    localparam int          MIX_LEN     = 200;

    typedef struct packed {
        logic        [mhpq_pkg::STATUS_W-1:0] status;
        logic signed [mhpq_pkg::KEY_W-1:0]    removed_key;
        logic signed [mhpq_pkg::KEY_W-1:0]    top_key;
        logic        [mhpq_pkg::COUNT_W-1:0]  count;
    } t_heap_result;

    logic                                 i_clk   = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 i_mode  = mhpq_pkg::MODE_INSERT;
    logic signed [mhpq_pkg::KEY_W-1:0]    i_key   = '0;
    logic                                 i_stall = 1'b0;
    logic                                 o_stall;
    logic                                 o_valid;
    logic        [mhpq_pkg::STATUS_W-1:0] o_status;
    logic signed [mhpq_pkg::KEY_W-1:0]    o_removed_key;
    logic signed [mhpq_pkg::KEY_W-1:0]    o_top_key;
    logic        [mhpq_pkg::COUNT_W-1:0]  o_count;

    // heap mirror and pending results
    logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [CAP];
    int unsigned                       heap_len = 0;
    t_heap_result                      pending_results[$];
    int                                mismatches = 0;
    int unsigned                       snd_idle_pct = 0;
    int unsigned                       rcv_idle_pct = 0;

    always #4 i_clk = ~i_clk;

    max_heap_priority_queue #(
        .CAPACITY (CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_removed_key (o_removed_key),
        .o_top_key     (o_top_key),
        .o_count       (o_count)
    );

    function automatic t_heap_result apply_request(
        input logic mode,
        input logic signed [mhpq_pkg::KEY_W-1:0] key
    );
        t_heap_result                      res;
        int unsigned                       pos;
        int unsigned                       parent;
        int unsigned                       pick;
        int unsigned                       lc;
        int unsigned                       rc;
        logic signed [mhpq_pkg::KEY_W-1:0] tmp;
        res = '0;
        res.status = mhpq_pkg::ST_OK;
        if (mode == mhpq_pkg::MODE_INSERT) begin
            if (heap_len >= CAP) begin
                res.status = mhpq_pkg::ST_FULL;
            end else begin
                pos = heap_len;
                heap_keys[pos] = key;
                heap_len++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] <= heap_keys[parent])
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[parent];
                    heap_keys[parent] = tmp;
                    pos = parent;
                end
            end
        end else if (heap_len == 0) begin
            res.status = mhpq_pkg::ST_EMPTY;
        end else begin
            res.removed_key = heap_keys[0];
            heap_len--;
            heap_keys[0] = heap_keys[heap_len];
            pos = 0;
            while (1) begin
                pick = pos;
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                if (lc < heap_len && heap_keys[lc] > heap_keys[pick])
                    pick = lc;
                if (rc < heap_len && heap_keys[rc] > heap_keys[pick])
                    pick = rc;
                if (pick == pos)
                    break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[pick];
                heap_keys[pick] = tmp;
                pos = pick;
            end
        end
        res.top_key = (heap_len > 0) ? heap_keys[0] : '0;
        res.count   = mhpq_pkg::COUNT_W'(heap_len);
        return res;
    endfunction

    // extremes, a narrow band for duplicates, and full-range values
    function automatic logic signed [mhpq_pkg::KEY_W-1:0] random_key();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed(32'($urandom_range(16))) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_request(input logic mode,
                                input logic signed [mhpq_pkg::KEY_W-1:0] key);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode  = mode;
        i_key   = key;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_results.push_back(apply_request(mode, key));
    endtask

    task automatic test_directed();
        send_request(mhpq_pkg::MODE_REMOVE, 32'sd0);
        send_request(mhpq_pkg::MODE_INSERT, 32'sd0);
        send_request(mhpq_pkg::MODE_REMOVE, -32'sd1);
        send_request(mhpq_pkg::MODE_REMOVE, 32'sh7FFF_FFFF);
        send_request(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
        send_request(mhpq_pkg::MODE_INSERT, 32'sh7FFF_FFFF);
        send_request(mhpq_pkg::MODE_INSERT, -32'sd1);
        send_request(mhpq_pkg::MODE_INSERT, 32'sd1);
        send_request(mhpq_pkg::MODE_INSERT, 32'sd5);
        send_request(mhpq_pkg::MODE_INSERT, 32'sd5);
        send_request(mhpq_pkg::MODE_INSERT, 32'sd5);
        send_request(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
        send_request(mhpq_pkg::MODE_INSERT, 32'sh7FFF_FFFF);
        repeat (10)
            send_request(mhpq_pkg::MODE_REMOVE, $signed($urandom));
    endtask

    // fill past capacity, then drain past empty
    task automatic test_fill_drain();
        repeat (CAP + 2)
            send_request(mhpq_pkg::MODE_INSERT, random_key());
        repeat (CAP + 2)
            send_request(mhpq_pkg::MODE_REMOVE, $signed($urandom));
    endtask

    task automatic test_random_mix(input int n);
        logic        mode;
        int unsigned ins_pct;
        repeat (n) begin
            if (heap_len == 0)
                ins_pct = 90;
            else if (heap_len >= CAP)
                ins_pct = 10;
            else
                ins_pct = 55;
            mode = ($urandom_range(99) < ins_pct) ? mhpq_pkg::MODE_INSERT
                                                  : mhpq_pkg::MODE_REMOVE;
            send_request(mode, random_key());
        end
    endtask

    always @(negedge i_clk)
        i_stall = ($urandom_range(99) < rcv_idle_pct);

    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d removed=%0d top=%0d count=%0d",
                             $realtime, o_status, o_removed_key, o_top_key, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_removed_key !== want.removed_key ||
                    o_top_key !== want.top_key || o_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: exp status=%0d removed=%0d top=%0d count=%0d, ",
                                  "got status=%0d removed=%0d top=%0d count=%0d"},
                                 $realtime, want.status, want.removed_key, want.top_key,
                                 want.count, o_status, o_removed_key, o_top_key, o_count);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 13;
                    rcv_idle_pct = 46;
                end
                1: begin
                    snd_idle_pct = 46;
                    rcv_idle_pct = 13;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                test_directed();
            test_fill_drain();
            test_random_mix(MIX_LEN);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
sv/mhpq_pkg.sv
sv/mhpq_cell.sv
sv/max_heap_priority_queue.sv
tb/tb_max_heap_priority_queue.sv
